[src/bbc_pkg.sv]
// bbc_pkg: shared types, constants and character decode for the bracket
// balance checker. No dependencies; imported by every module in src.
package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;
  localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
  localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    FAULT_NONE        = 3'd0,
    FAULT_EMPTY_CLOSE = 3'd1,
    FAULT_MISMATCH    = 3'd2,
    FAULT_UNCLOSED    = 3'd3,
    FAULT_OVERFLOW    = 3'd4
  } fault_t;

  typedef struct packed {
    logic   balanced;
    fault_t fault;
  } verdict_t;

  function automatic kind_t open_kind(input logic [7:0] ch);
    kind_t k;
    case (ch)
      CHAR_ROUND_OPEN:  k = KIND_ROUND;
      CHAR_SQUARE_OPEN: k = KIND_SQUARE;
      CHAR_CURLY_OPEN:  k = KIND_CURLY;
      default:          k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] ch);
    kind_t k;
    case (ch)
      CHAR_ROUND_CLOSE:  k = KIND_ROUND;
      CHAR_SQUARE_CLOSE: k = KIND_SQUARE;
      CHAR_CURLY_CLOSE:  k = KIND_CURLY;
      default:           k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[src/bbc_stack.sv]
// bbc_stack: bracket stack held in a synchronous memory, with the top entry
// in a register and the entry below it prefetched every cycle.
// Depends on bbc_pkg.
module bbc_stack
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       res_valid,
  output verdict_t   res
);

  kind_t               mem [STACK_DEPTH];
  kind_t               rd_data;
  kind_t               top;
  kind_t               top_next;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   fill_next;
  fault_t              first_fault;
  fault_t              first_fault_next;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [FILL_W-1:0]   below_next;
  logic                line_end;
  kind_t               ok;
  kind_t               ck;
  fault_t              line_fault;

  assign line_end = end_of_text || (char_code == CHAR_NEWLINE);
  assign ok       = open_kind(char_code);
  assign ck       = close_kind(char_code);
  assign wr_addr  = fill[ADDR_W-1:0];

  always_comb begin
    fill_next        = fill;
    top_next         = top;
    first_fault_next = first_fault;
    wr_en            = 1'b0;
    res_valid        = 1'b0;
    line_fault       = first_fault;
    if ((first_fault == FAULT_NONE) && (fill != '0)) begin
      line_fault = FAULT_UNCLOSED;
    end
    res.fault    = line_fault;
    res.balanced = (line_fault == FAULT_NONE);
    if (take) begin
      if (line_end) begin
        res_valid        = 1'b1;
        fill_next        = '0;
        first_fault_next = FAULT_NONE;
      end else if (first_fault == FAULT_NONE) begin
        if (ok != KIND_NONE) begin
          if (fill == FILL_W'(STACK_DEPTH)) begin
            first_fault_next = FAULT_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            fill_next = fill + FILL_W'(1);
            top_next  = ok;
          end
        end else if (ck != KIND_NONE) begin
          if (fill == '0) begin
            first_fault_next = FAULT_EMPTY_CLOSE;
          end else if (top != ck) begin
            first_fault_next = FAULT_MISMATCH;
          end else begin
            fill_next = fill - FILL_W'(1);
            top_next  = rd_data;
          end
        end
      end
    end
  end

  // prefetch the entry under the next top
  assign below_next = fill_next - FILL_W'(2);
  assign rd_addr    = below_next[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= ok;
    end
    rd_data <= mem[rd_addr];
    top     <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      first_fault <= FAULT_NONE;
    end else begin
      fill        <= fill_next;
      first_fault <= first_fault_next;
    end
  end

endmodule

[src/bbc_out_buf.sv]
// bbc_out_buf: verdict output register with a skid entry behind it.
// Depends on bbc_pkg.
module bbc_out_buf
  import bbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  input  verdict_t res,
  input  logic     verdict_stall,
  output logic     verdict_valid,
  output verdict_t verdict,
  output logic     full
);

  verdict_t skid;
  logic     skid_valid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!verdict_valid || !verdict_stall) begin
      if (skid_valid) begin
        verdict_valid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        verdict_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!verdict_valid || !verdict_stall) begin
      verdict <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

endmodule

[src/bracket_balance_checker.sv]
// One character item is taken every cycle unless char_stall is high. A line
// end's verdict goes to the output register, or to the skid entry while that
// register is held by verdict_stall. The bracket stack is a STACK_DEPTH x 2 bit
// memory with synchronous read; the top entry sits in a register and the entry
// below it is read ahead every cycle, so pushes and pops run back to back.
// char_stall rises only while two verdicts wait (output register and skid entry
// both held by verdict_stall). Depends on bbc_pkg, bbc_stack and bbc_out_buf.
module bracket_balance_checker
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic       balanced,
  output logic [2:0] fault
);

  logic     take;
  logic     res_valid;
  verdict_t res;
  verdict_t verdict;
  logic     full;

  assign char_stall = full;
  assign take       = char_valid && !char_stall;

  bbc_stack u_stack (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .res_valid   (res_valid),
    .res         (res)
  );

  bbc_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .verdict_stall (verdict_stall),
    .verdict_valid (verdict_valid),
    .verdict       (verdict),
    .full          (full)
  );

  assign balanced = verdict.balanced;
  assign fault    = 3'(verdict.fault);

endmodule

[src/bbc_checker.sv]
// bbc_checker: port-level assertions for bracket_balance_checker, bound to
// the top level below. Depends on bbc_pkg.
module bbc_checker
  import bbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic [7:0] char_code,
  input logic       end_of_text,
  input logic       verdict_valid,
  input logic       verdict_stall,
  input logic       balanced,
  input logic [2:0] fault
);

  a_held: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=>
      verdict_valid && $stable(balanced) && $stable(fault))
    else $error("stalled verdict changed");

  a_bal: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (balanced == (fault == 3'(FAULT_NONE))))
    else $error("balanced disagrees with fault");

  a_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (fault <= 3'(FAULT_OVERFLOW)))
    else $error("fault code out of range");

  a_line: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && (end_of_text || (char_code == CHAR_NEWLINE))
      |=> verdict_valid)
    else $error("line end gave no verdict");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .char_valid    (char_valid),
  .char_stall    (char_stall),
  .char_code     (char_code),
  .end_of_text   (end_of_text),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall),
  .balanced      (balanced),
  .fault         (fault)
);

[verif/tb_bracket_balance_checker.sv]
// Self-checking testbench for bracket_balance_checker: a directed table of lines, then
// random lines, each verdict compared with its row's typed expectation or else an in-bench bracket stack predictor.
// Depends on bbc_pkg and bracket_balance_checker from src.
module tb_bracket_balance_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int PAUSE_EVERY  = 300;
  localparam verdict_t UNTYPED = '{1'b0, FAULT_NONE};

  typedef struct {
    logic [7:0] code;
    logic       eot;
  } char_item_t;

  typedef struct {
    logic [7:0] code;
    logic       eot;
    bit         typed;
    verdict_t   v;
  } script_row_t;

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  logic [7:0] char_code;
  logic       end_of_text;
  logic       verdict_valid;
  logic       verdict_stall;
  logic       balanced;
  logic [2:0] fault;

  // typed expectation that travels with the item
  bit       row_typed;
  verdict_t row_verdict;

  verdict_t   pending_verdicts[$];
  char_item_t line_chars[$];
  int         mismatch_count = 0;

  kind_t       bracket_stack [STACK_DEPTH];
  int unsigned stack_fill = 0;
  fault_t      line_fault = FAULT_NONE;

  logic [7:0] open_char  [3] = '{CHAR_ROUND_OPEN, CHAR_SQUARE_OPEN, CHAR_CURLY_OPEN};
  logic [7:0] close_char [3] = '{CHAR_ROUND_CLOSE, CHAR_SQUARE_CLOSE, CHAR_CURLY_CLOSE};

  script_row_t directed_rows [25] = '{
    '{CHAR_NEWLINE,      1'b0, 1'b1, '{1'b1, FAULT_NONE}},
    '{CHAR_ROUND_CLOSE,  1'b0, 1'b0, UNTYPED},
    '{CHAR_NEWLINE,      1'b0, 1'b1, '{1'b0, FAULT_EMPTY_CLOSE}},
    '{CHAR_ROUND_OPEN,   1'b0, 1'b0, UNTYPED},
    '{CHAR_SQUARE_CLOSE, 1'b0, 1'b0, UNTYPED},
    '{CHAR_NEWLINE,      1'b0, 1'b1, '{1'b0, FAULT_MISMATCH}},
    '{CHAR_SQUARE_OPEN,  1'b0, 1'b0, UNTYPED},
    '{8'h00,             1'b1, 1'b1, '{1'b0, FAULT_UNCLOSED}},
    '{CHAR_CURLY_OPEN,   1'b0, 1'b0, UNTYPED},
    '{CHAR_ROUND_OPEN,   1'b0, 1'b0, UNTYPED},
    '{8'hFF,             1'b0, 1'b0, UNTYPED},
    '{CHAR_ROUND_CLOSE,  1'b0, 1'b0, UNTYPED},
    '{CHAR_CURLY_CLOSE,  1'b0, 1'b0, UNTYPED},
    '{CHAR_NEWLINE,      1'b1, 1'b1, '{1'b1, FAULT_NONE}},
    '{CHAR_CURLY_CLOSE,  1'b0, 1'b0, UNTYPED},
    '{CHAR_ROUND_OPEN,   1'b0, 1'b0, UNTYPED},
    '{CHAR_NEWLINE,      1'b0, 1'b1, '{1'b0, FAULT_EMPTY_CLOSE}},
    '{CHAR_SQUARE_OPEN,  1'b0, 1'b0, UNTYPED},
    '{CHAR_CURLY_CLOSE,  1'b0, 1'b0, UNTYPED},
    '{CHAR_SQUARE_CLOSE, 1'b0, 1'b0, UNTYPED},
    '{CHAR_NEWLINE,      1'b0, 1'b1, '{1'b0, FAULT_MISMATCH}},
    '{8'h09,             1'b0, 1'b0, UNTYPED},
    '{CHAR_ROUND_OPEN,   1'b1, 1'b1, '{1'b1, FAULT_NONE}},
    '{CHAR_CURLY_OPEN,   1'b0, 1'b0, UNTYPED},
    '{CHAR_NEWLINE,      1'b0, 1'b0, UNTYPED}
  };

  bracket_balance_checker dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .end_of_text   (end_of_text),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .balanced      (balanced),
    .fault         (fault)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // advances the bracket stack by one item; returns 1 when the line ends
  function automatic bit track_char(input logic [7:0] code, input logic eot,
                                    output verdict_t v);
    kind_t opener;
    kind_t closer;
    v = '{1'b1, FAULT_NONE};
    if (eot || code == CHAR_NEWLINE) begin
      v.fault = line_fault;
      if (line_fault == FAULT_NONE && stack_fill != 0) v.fault = FAULT_UNCLOSED;
      v.balanced = (v.fault == FAULT_NONE);
      stack_fill = 0;
      line_fault = FAULT_NONE;
      return 1'b1;
    end
    if (line_fault != FAULT_NONE) return 1'b0;
    opener = KIND_NONE;
    closer = KIND_NONE;
    case (code)
      CHAR_ROUND_OPEN:   opener = KIND_ROUND;
      CHAR_SQUARE_OPEN:  opener = KIND_SQUARE;
      CHAR_CURLY_OPEN:   opener = KIND_CURLY;
      CHAR_ROUND_CLOSE:  closer = KIND_ROUND;
      CHAR_SQUARE_CLOSE: closer = KIND_SQUARE;
      CHAR_CURLY_CLOSE:  closer = KIND_CURLY;
      default: ;
    endcase
    if (opener != KIND_NONE) begin
      if (stack_fill == STACK_DEPTH) begin
        line_fault = FAULT_OVERFLOW;
      end else begin
        bracket_stack[stack_fill] = opener;
        stack_fill++;
      end
    end else if (closer != KIND_NONE) begin
      if (stack_fill == 0) begin
        line_fault = FAULT_EMPTY_CLOSE;
      end else if (bracket_stack[stack_fill - 1] != closer) begin
        line_fault = FAULT_MISMATCH;
      end else begin
        stack_fill--;
      end
    end
    return 1'b0;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    verdict_t predicted;
    verdict_t want;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        if (track_char(char_code, end_of_text, predicted))
          pending_verdicts.push_back(row_typed ? row_verdict : predicted);
      end
      if (verdict_valid && !verdict_stall) begin
        if (pending_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected verdict: balanced=%0b fault=%0d",
                                 balanced, fault));
        end else begin
          want = pending_verdicts.pop_front();
          if (balanced !== want.balanced || fault !== want.fault)
            note_failure($sformatf("verdict mismatch: expected balanced=%0b fault=%0d, got balanced=%0b fault=%0d",
                                   want.balanced, want.fault, balanced, fault));
        end
      end
    end
  end

  // receiver: random stall before each verdict, some stretches without
  initial begin
    int n;
    verdict_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        verdict_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      verdict_stall <= 1'b0;
      @(posedge clk);
      while (!(verdict_valid && !verdict_stall)) @(posedge clk);
    end
  end

  task automatic send_char(input logic [7:0] code, input logic eot, input bit typed,
                           input verdict_t v, input int gap);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid  <= 1'b1;
    char_code   <= code;
    end_of_text <= eot;
    row_typed   <= typed;
    row_verdict <= v;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  task automatic wait_for_verdicts();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_bracket();
    int k;
    k = $urandom_range(0, 5);
    return (k < 3) ? open_char[k] : close_char[k - 3];
  endfunction

  // one line: deep nesting, nested text with occasional damage, or noise
  task automatic build_line();
    int   mode;
    int   len;
    int   k;
    int   open_kinds[$];
    logic [7:0] c;
    line_chars.delete();
    mode = $urandom_range(0, 99);
    if (mode < 4) begin
      len = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      repeat (len) begin
        k = $urandom_range(0, 2);
        open_kinds.push_back(k);
        line_chars.push_back('{open_char[k], 1'b0});
      end
      while (open_kinds.size() != 0)
        line_chars.push_back('{close_char[open_kinds.pop_back()], 1'b0});
    end else if (mode < 70) begin
      len = $urandom_range(0, 24);
      repeat (len) begin
        k = $urandom_range(0, 9);
        if (k < 4 && open_kinds.size() < 12) begin
          k = $urandom_range(0, 2);
          open_kinds.push_back(k);
          line_chars.push_back('{open_char[k], 1'b0});
        end else if (k < 7 && open_kinds.size() > 0) begin
          line_chars.push_back('{close_char[open_kinds.pop_back()], 1'b0});
        end else begin
          line_chars.push_back('{8'($urandom_range(97, 122)), 1'b0});
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        while (open_kinds.size() != 0)
          line_chars.push_back('{close_char[open_kinds.pop_back()], 1'b0});
      end
      if ($urandom_range(0, 4) == 0 && line_chars.size() > 0)
        line_chars[$urandom_range(0, line_chars.size() - 1)].code = any_bracket();
    end else begin
      len = $urandom_range(0, 15);
      repeat (len) begin
        c = $urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255));
        line_chars.push_back('{c, 1'b0});
      end
    end
    if ($urandom_range(0, 4) == 0) line_chars.push_back('{8'($urandom_range(0, 255)), 1'b1});
    else line_chars.push_back('{CHAR_NEWLINE, 1'b0});
  endtask

  initial begin
    int sent;
    int next_pause;
    bit idle_on;
    rst           = 1'b1;
    char_valid    = 1'b0;
    char_code     = 8'h00;
    end_of_text   = 1'b0;
    row_typed     = 1'b0;
    row_verdict   = UNTYPED;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_char(directed_rows[i].code, directed_rows[i].eot, directed_rows[i].typed,
                directed_rows[i].v, $urandom_range(0, 18));
    wait_for_verdicts();

    sent = 0;
    next_pause = PAUSE_EVERY;
    while (sent < RANDOM_ITEMS) begin
      build_line();
      idle_on = ($urandom_range(0, 2) != 0);
      foreach (line_chars[i]) begin
        send_char(line_chars[i].code, line_chars[i].eot, 1'b0, UNTYPED,
                  idle_on ? $urandom_range(0, 18) : 0);
        sent++;
      end
      if (sent >= next_pause) begin
        wait_for_verdicts();
        next_pause += PAUSE_EVERY;
      end
    end

    wait_for_verdicts();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
